>>> sv/nha_pkg.sv
// ----------------------------------------------------------------------------
// nha_pkg
// Types and fixed widths shared by the nearest head assignment core.
// ----------------------------------------------------------------------------
package nha_pkg;

    // Fixed field widths of the node and result beats
    localparam int COORD_W    = 16;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int NODE_IDX_W = 6;
    localparam int HEAD_IDX_W = 7;

    // One stored node: coordinates and head flag
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               head;
    } node_entry_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_NODE,
        ST_WAIT_NODE,
        ST_SWEEP,
        ST_DRAIN
    } nha_state_t;

endpackage

>>> sv/nearest_head_assignment_core.sv
// ----------------------------------------------------------------------------
// nearest_head_assignment_core
// Loads a set of node points, then assigns each node to its nearest head.
// ----------------------------------------------------------------------------
// Nodes are loaded one beat per start (while busy is low); the beat with
// last_node set, or the beat that fills the final store entry, closes the set
// and raises busy. The core then strobes result_valid once per node in index
// order and drops busy with the final result. Results cannot be held off, so
// the receiver must take each one in the cycle it appears. A head node (or any
// node of a set with no head) gets its result straight from the node read;
// every other node is resolved by a sweep of the whole set through the single
// read port of the node store, which supplies one candidate node per cycle to
// the distance pipeline (abs difference, squares, sum and compare), then by a
// pipeline drain, longer when the final candidates of the sweep are heads.
// ----------------------------------------------------------------------------
module nearest_head_assignment_core
    import nha_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    x_coord,
    input  logic [COORD_W-1:0]    y_coord,
    input  logic                  is_head,
    input  logic                  last_node,
    output logic                  result_valid,
    output logic [NODE_IDX_W-1:0] node_index,
    output logic [HEAD_IDX_W-1:0] head_index,
    output logic [DIST_W-1:0]     dist_squared,
    output logic                  no_head,
    output logic                  last_result
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_NODES - 1);
    localparam logic [HEAD_IDX_W-1:0] NO_HEAD_IDX = HEAD_IDX_W'(MAX_NODES);

    // Node store and its registered read port
    node_entry_t node_mem [MAX_NODES];
    node_entry_t rd_data_reg;
    logic        wr_en;
    logic        rd_en;
    logic [IDX_W-1:0] rd_addr;

    // Control state
    nha_state_t       state_reg, state_next;
    logic [IDX_W-1:0] load_count_reg, load_count_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             any_head_reg, any_head_next;
    logic             p0_valid_reg, p0_valid_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s2_valid_reg, s2_valid_next;
    logic             found_reg, found_next;
    logic             valid_reg, valid_next;

    // Datapath state
    logic [COORD_W-1:0]    nx_reg, nx_next;
    logic [COORD_W-1:0]    ny_reg, ny_next;
    logic [IDX_W-1:0]      p0_idx_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic [IDX_W-1:0]      s2_idx_reg;
    logic [COORD_W-1:0]    dx_reg, dy_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [DIST_W-1:0]     best_d_reg, best_d_next;
    logic [IDX_W-1:0]      best_j_reg, best_j_next;
    logic [NODE_IDX_W-1:0] out_node_reg, out_node_next;
    logic [HEAD_IDX_W-1:0] out_head_reg, out_head_next;
    logic [DIST_W-1:0]     out_dist_reg, out_dist_next;
    logic                  out_none_reg, out_none_next;
    logic                  out_last_reg, out_last_next;

    logic [DIST_W-1:0] s3_dist;
    logic              closes;

    assign closes  = last_node || (load_count_reg == LAST_SLOT);
    assign s3_dist = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    // Store write on a load beat, registered read otherwise; busy keeps the
    // two apart, so no entry is read in the cycle it is written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[load_count_reg] <= '{x: x_coord, y: y_coord, head: is_head};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    // Sequencer and best-head tracking
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        last_next       = last_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        any_head_next   = any_head_reg;
        p0_valid_next   = 1'b0;
        found_next      = found_reg;
        best_d_next     = best_d_reg;
        best_j_next     = best_j_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        valid_next      = 1'b0;
        out_node_next   = out_node_reg;
        out_head_next   = out_head_reg;
        out_dist_next   = out_dist_reg;
        out_none_next   = out_none_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = i_reg;

        // Distance pipeline, final stage: keep the strictly nearer head
        if (s2_valid_reg && (!found_reg || s3_dist < best_d_reg))
        begin
            found_next  = 1'b1;
            best_d_next = s3_dist;
            best_j_next = s2_idx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    wr_en         = 1'b1;
                    any_head_next = ((load_count_reg == '0) ? 1'b0 : any_head_reg) | is_head;
                    if (closes)
                    begin
                        last_next       = load_count_reg;
                        load_count_next = '0;
                        i_next          = '0;
                        state_next      = ST_READ_NODE;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + 1'b1;
                    end
                end
            end
            ST_READ_NODE:
            begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = ST_WAIT_NODE;
            end
            ST_WAIT_NODE:
            begin
                nx_next       = rd_data_reg.x;
                ny_next       = rd_data_reg.y;
                out_node_next = NODE_IDX_W'(i_reg);
                out_dist_next = '0;
                out_none_next = !any_head_reg;
                out_last_next = (i_reg == last_reg);
                if (!any_head_reg || rd_data_reg.head)
                begin
                    // head or headless set: result is known at once
                    valid_next    = 1'b1;
                    out_head_next = any_head_reg ? HEAD_IDX_W'(i_reg) : NO_HEAD_IDX;
                    if (i_reg == last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_READ_NODE;
                    end
                end
                else
                begin
                    found_next = 1'b0;
                    j_next     = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                // one candidate read per cycle
                rd_en         = 1'b1;
                rd_addr       = j_reg;
                p0_valid_next = 1'b1;
                if (j_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!p0_valid_reg && !s1_valid_reg && !s2_valid_reg)
                begin
                    valid_next    = 1'b1;
                    out_head_next = HEAD_IDX_W'(best_j_reg);
                    out_dist_next = best_d_reg;
                    if (i_reg == last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_READ_NODE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Candidate stages: only heads travel on
    assign s1_valid_next = p0_valid_reg && rd_data_reg.head;
    assign s2_valid_next = s1_valid_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            load_count_reg <= '0;
            last_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            any_head_reg   <= 1'b0;
            p0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            last_reg       <= last_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            any_head_reg   <= any_head_next;
            p0_valid_reg   <= p0_valid_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            found_reg      <= found_next;
            valid_reg      <= valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        p0_idx_reg   <= j_reg;
        s1_idx_reg   <= p0_idx_reg;
        s2_idx_reg   <= s1_idx_reg;
        dx_reg       <= (nx_reg >= rd_data_reg.x) ? (nx_reg - rd_data_reg.x)
                                                  : (rd_data_reg.x - nx_reg);
        dy_reg       <= (ny_reg >= rd_data_reg.y) ? (ny_reg - rd_data_reg.y)
                                                  : (rd_data_reg.y - ny_reg);
        sqx_reg      <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg      <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        best_d_reg   <= best_d_next;
        best_j_reg   <= best_j_next;
        out_node_reg <= out_node_next;
        out_head_reg <= out_head_next;
        out_dist_reg <= out_dist_next;
        out_none_reg <= out_none_next;
        out_last_reg <= out_last_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign node_index   = out_node_reg;
    assign head_index   = out_head_reg;
    assign dist_squared = out_dist_reg;
    assign no_head      = out_none_reg;
    assign last_result  = out_last_reg;

`ifndef NO_ASSERTIONS
    // a result only follows a busy cycle
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result beat without a busy cycle before it");

    // a closing load beat starts the result phase
    a_close_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (last_node || load_count_reg == LAST_SLOT)) |=> busy)
        else $error("closing beat did not raise busy");

    // busy drops exactly with the final result
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last_result == !busy))
        else $error("busy out of step with the final result");

    // headless set gives the marker index at zero distance
    a_no_head_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && no_head) |-> (head_index == NO_HEAD_IDX && dist_squared == '0))
        else $error("headless result malformed");
`endif

endmodule

>>> verif/nha_assign_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nha_assign_checker
// Watches the node and result channels of the nearest head assignment core.
// ----------------------------------------------------------------------------
// Every node beat taken by the core is copied into a private node store. When
// a beat closes the set (last_node, or the store fills), the assignment of
// every node to its nearest head is worked out and queued in index order.
// Each result strobe is compared field by field with the oldest queued
// assignment. Counts go back to the top for the verdict and the summary.
// ----------------------------------------------------------------------------
module nha_assign_checker
    import nha_pkg::*;
#(
    parameter int MAX_NODES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [COORD_W-1:0]    x_coord,
    input  logic [COORD_W-1:0]    y_coord,
    input  logic                  is_head,
    input  logic                  last_node,
    input  logic                  result_valid,
    input  logic [NODE_IDX_W-1:0] node_index,
    input  logic [HEAD_IDX_W-1:0] head_index,
    input  logic [DIST_W-1:0]     dist_squared,
    input  logic                  no_head,
    input  logic                  last_result,
    output int                    mismatch_count,
    output int                    pending_results,
    output int                    results_checked,
    output int                    sets_closed,
    output int                    headless_sets,
    output int                    full_sets
);

    // One node assignment as it should appear on the result ports
    typedef struct packed {
        logic [NODE_IDX_W-1:0] node;
        logic [HEAD_IDX_W-1:0] head;
        logic [DIST_W-1:0]     dsq;
        logic                  no_head;
        logic                  last;
    } assignment_t;

    node_entry_t node_store [MAX_NODES];
    int          fill_count;
    assignment_t assignment_q [$];
    int          errors;
    int          checked;
    int          closed;
    int          headless;
    int          full;

    // Exact squared distance between two stored points
    function automatic logic [DIST_W-1:0] span_squared(node_entry_t a, node_entry_t b);
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
        dx = DIST_W'((a.x >= b.x) ? a.x - b.x : b.x - a.x);
        dy = DIST_W'((a.y >= b.y) ? a.y - b.y : b.y - a.y);
        return dx * dx + dy * dy;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] assignment error: %s", $time, msg);
        errors++;
    endtask

    // Work out the nearest head of every node in the closed set
    task automatic assign_nearest_heads(input int total);
        logic              any_head;
        logic              found;
        logic [DIST_W-1:0] d;
        assignment_t       r;
        any_head = 1'b0;
        for (int i = 0; i < total; i++)
            any_head |= node_store[i].head;
        closed++;
        if (!any_head)
            headless++;
        if (total == MAX_NODES)
            full++;
        for (int i = 0; i < total; i++)
        begin
            r.node    = NODE_IDX_W'(i);
            r.dsq     = '0;
            r.no_head = !any_head;
            r.last    = (i == total - 1);
            if (!any_head)
                r.head = HEAD_IDX_W'(MAX_NODES);
            else if (node_store[i].head)
                r.head = HEAD_IDX_W'(i);
            else
            begin
                // strict compare keeps the lowest index on equal distance
                found = 1'b0;
                for (int j = 0; j < total; j++)
                begin
                    if (node_store[j].head)
                    begin
                        d = span_squared(node_store[i], node_store[j]);
                        if (!found || d < r.dsq)
                        begin
                            r.dsq  = d;
                            r.head = HEAD_IDX_W'(j);
                            found  = 1'b1;
                        end
                    end
                end
            end
            assignment_q = {assignment_q, r};
        end
    endtask

    // Store one node beat; close the set on last_node or a full store
    task automatic take_node();
        int slot;
        int total;
        slot = (fill_count >= MAX_NODES) ? 0 : fill_count;
        node_store[slot] = '{x: x_coord, y: y_coord, head: is_head};
        total = slot + 1;
        if (last_node || total >= MAX_NODES)
        begin
            assign_nearest_heads(total);
            fill_count = 0;
        end
        else
            fill_count = total;
    endtask

    // Compare one result beat with the oldest queued assignment
    task automatic check_result();
        assignment_t want;
        if (assignment_q.size() == 0)
        begin
            report_mismatch($sformatf("result for node %0d with nothing outstanding",
                                      node_index));
            return;
        end
        want = assignment_q.pop_front();
        checked++;
        if (node_index !== want.node)
            report_mismatch($sformatf("node_index expected %0d, got %0d",
                                      want.node, node_index));
        if (head_index !== want.head)
            report_mismatch($sformatf("node %0d: head_index expected %0d, got %0d",
                                      want.node, want.head, head_index));
        if (dist_squared !== want.dsq)
            report_mismatch($sformatf("node %0d: dist_squared expected %0d, got %0d",
                                      want.node, want.dsq, dist_squared));
        if (no_head !== want.no_head)
            report_mismatch($sformatf("node %0d: no_head expected %0b, got %0b",
                                      want.node, want.no_head, no_head));
        if (last_result !== want.last)
            report_mismatch($sformatf("node %0d: last_result expected %0b, got %0b",
                                      want.node, want.last, last_result));
    endtask

    // Results are checked before a node beat of the same edge is taken in
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count = 0;
            assignment_q.delete();
        end
        else
        begin
            if (result_valid !== 1'b0)
                check_result();
            if (start && !busy)
                take_node();
        end
        mismatch_count  <= errors;
        pending_results <= assignment_q.size();
        results_checked <= checked;
        sets_closed     <= closed;
        headless_sets   <= headless;
        full_sets       <= full;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Node set stimulus and verdict for the nearest head assignment core.
// ----------------------------------------------------------------------------
// Loads a directed group of small node sets (lone nodes, extreme coordinates,
// equal distances, sets with no head and sets of heads only), then random
// sets of mixed size, head density and coordinate spread, including sets
// that fill the store. The sender idles at random between beats; the
// assignment checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top
    import nha_pkg::*;
();

    localparam int                 NODE_SLOTS    = 64;
    localparam int                 TOTAL_NODES   = 460;
    localparam int                 GAP_MAX       = 16;
    localparam int                 RESET_CYCLES  = 6;
    localparam int                 SETTLE_CYCLES = 100;
    localparam int                 CYCLE_LIMIT   = 500000;
    localparam logic [COORD_W-1:0] COORD_MAX     = '1;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic [COORD_W-1:0]    x_coord      = '0;
    logic [COORD_W-1:0]    y_coord      = '0;
    logic                  is_head      = 1'b0;
    logic                  last_node    = 1'b0;
    logic                  busy;
    logic                  result_valid;
    logic [NODE_IDX_W-1:0] node_index;
    logic [HEAD_IDX_W-1:0] head_index;
    logic [DIST_W-1:0]     dist_squared;
    logic                  no_head;
    logic                  last_result;

    int mismatch_count;
    int pending_results;
    int results_checked;
    int sets_closed;
    int headless_sets;
    int full_sets;

    int gap_ceiling;
    int nodes_loaded;
    int cycle_count;

    nearest_head_assignment_core #(
        .MAX_NODES (NODE_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .is_head      (is_head),
        .last_node    (last_node),
        .result_valid (result_valid),
        .node_index   (node_index),
        .head_index   (head_index),
        .dist_squared (dist_squared),
        .no_head      (no_head),
        .last_result  (last_result)
    );

    nha_assign_checker #(
        .MAX_NODES (NODE_SLOTS)
    ) u_assign_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .is_head         (is_head),
        .last_node       (last_node),
        .result_valid    (result_valid),
        .node_index      (node_index),
        .head_index      (head_index),
        .dist_squared    (dist_squared),
        .no_head         (no_head),
        .last_result     (last_result),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked),
        .sets_closed     (sets_closed),
        .headless_sets   (headless_sets),
        .full_sets       (full_sets)
    );

    // 100 MHz clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, pending_results);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One node beat after a random gap; start stays high for a back-to-back beat
    task automatic put_node(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic h, input logic l);
        int gap;
        gap = (gap_ceiling == 0) ? 0 : $urandom_range(0, gap_ceiling);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        x_coord   <= x;
        y_coord   <= y;
        is_head   <= h;
        last_node <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        nodes_loaded++;
    endtask

    // Hold the sender off until every queued assignment has come out
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int                 pick;
        int                 set_size;
        int                 head_mode;
        int                 coord_mode;
        int                 set_count;
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               h;
        logic               l;

        nodes_loaded = 0;
        set_count    = 0;
        gap_ceiling  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone head at the far corner
        put_node(COORD_MAX, COORD_MAX, 1'b1, 1'b1);
        // lone plain node: set without a head
        put_node('0, '0, 1'b0, 1'b1);
        // head at the origin, plain node at the far corner: largest distance
        put_node('0, '0, 1'b1, 1'b0);
        put_node(COORD_MAX, COORD_MAX, 1'b0, 1'b1);
        // three heads at equal distance from node 1: lowest index wins
        gap_ceiling = GAP_MAX;
        put_node(16'd300, 16'd100, 1'b1, 1'b0);
        put_node(16'd200, 16'd100, 1'b0, 1'b0);
        put_node(16'd100, 16'd100, 1'b1, 1'b0);
        put_node(16'd300, 16'd100, 1'b1, 1'b1);
        // no head, alternating bit patterns
        put_node(16'hAAAA, 16'h5555, 1'b0, 1'b0);
        put_node(16'h5555, 16'hAAAA, 1'b0, 1'b0);
        put_node(COORD_MAX, '0, 1'b0, 1'b1);
        // heads only
        gap_ceiling = 0;
        put_node(16'h0001, 16'h8000, 1'b1, 1'b0);
        put_node(16'h8000, 16'h0001, 1'b1, 1'b0);
        put_node(16'h1234, 16'hFEDC, 1'b1, 1'b1);
        wait_for_results();

        // Random sets; the first one fills the store without a last mark
        while (nodes_loaded < TOTAL_NODES)
        begin
            pick = $urandom_range(0, 99);
            if (set_count == 0 || pick < 5)
                set_size = NODE_SLOTS;
            else if (pick < 15)
                set_size = $urandom_range(11, 40);
            else
                set_size = $urandom_range(1, 10);
            head_mode   = $urandom_range(0, 9);
            coord_mode  = $urandom_range(0, 3);
            base_x      = COORD_W'($urandom);
            base_y      = COORD_W'($urandom);
            gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            for (int k = 0; k < set_size; k++)
            begin
                // head density: none, all, or roughly one in four
                case (head_mode)
                    0:       h = 1'b0;
                    1:       h = 1'b1;
                    default: h = ($urandom_range(0, 3) == 0);
                endcase
                // clustered points give many equal distances
                case (coord_mode)
                    0:
                    begin
                        x = base_x + COORD_W'($urandom_range(0, 3));
                        y = base_y + COORD_W'($urandom_range(0, 3));
                    end
                    1:
                    begin
                        x = $urandom_range(0, 1) ? COORD_MAX : '0;
                        y = $urandom_range(0, 1) ? COORD_MAX : '0;
                    end
                    default:
                    begin
                        x = COORD_W'($urandom);
                        y = COORD_W'($urandom);
                    end
                endcase
                if (k != set_size - 1)
                    l = 1'b0;
                else if (set_size == NODE_SLOTS)
                    l = (set_count == 0) ? 1'b0 : 1'($urandom_range(0, 1));
                else
                    l = 1'b1;
                put_node(x, y, h, l);
            end
            set_count++;
            if ($urandom_range(0, 6) == 0)
                wait_for_results();
        end

        // Drain and let any stray result show up
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Loaded %0d nodes in %0d sets: %0d without a head, %0d filling the store.",
                 nodes_loaded, sets_closed, headless_sets, full_sets);
        $display("Compared %0d node assignments: %0d mismatches, %0d still owed.",
                 results_checked, mismatch_count, pending_results);
        if (mismatch_count == 0 && pending_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
sv/nha_pkg.sv
sv/nearest_head_assignment_core.sv
verif/nha_assign_checker.sv
verif/tb_top.sv
